@@ sv/pbl_pkg.sv @@
// shared constants and types for the periodic bilinear pattern lookup
package pbl_pkg;

  localparam int AZ_POINTS  = 64;
  localparam int EL_POINTS  = 64;
  localparam int ANGLE_BITS = 16;

  localparam int AZ_BITS = $clog2(AZ_POINTS);
  localparam int EL_BITS = $clog2(EL_POINTS);

  localparam int SAMPLE_W = 16;
  localparam int EFF_W    = 16;
  localparam int GAIN_W   = 24;

  localparam logic [EFF_W-1:0]  EFF_RESET = EFF_W'(4096);
  localparam logic [GAIN_W-1:0] GAIN_MAX  = {GAIN_W{1'b1}};

  // blend result keeps this many fraction bits before the efficiency scale
  localparam int FRAC_OUT    = 8;
  localparam int ROUND_SHIFT = 20;

  // samples are banked by the parity of both grid indices
  localparam int NBANKS     = 4;
  localparam int BANK_SEL_W = 2;
  localparam int BANK_AW    = AZ_BITS + EL_BITS - 2;
  localparam int BANK_DEPTH = (AZ_POINTS * EL_POINTS) / NBANKS;

  // four neighbor samples and the two fractions of one query
  typedef struct packed {
    logic [SAMPLE_W-1:0]   s00;
    logic [SAMPLE_W-1:0]   s10;
    logic [SAMPLE_W-1:0]   s01;
    logic [SAMPLE_W-1:0]   s11;
    logic [ANGLE_BITS-1:0] t;
    logic [ANGLE_BITS-1:0] u;
  } pbl_taps_t;

endpackage

@@ sv/periodic_bilinear_pattern_lookup_unit.sv @@
// top level: angle split, banked pattern store and blend pipeline
//
// Periodic bilinear pattern lookup.
// Input channel: an item transfers on a rising edge with start high and busy
// low. busy is always low, so one item can transfer in every cycle. With
// in_operation high the item writes in_write_sample at grid point
// (in_write_az_index, in_write_el_index) and gives no result. With
// in_operation low it is a query: azimuth and elevation offsets from the
// boresight are split into grid index and fraction, the four wrapped
// neighbors are blended, scaled by the efficiency register and clipped.
// Result channel: out_gain and out_saturated are valid for the one cycle in
// which out_strobe is high, after stage 1, stage 2 and the blend pipeline.
// Results leave in query order at up to one per cycle. The receiver cannot
// stall. Throughput is one item per cycle: the store is split into four
// banks by index parity so the four neighbors are read in the same cycle,
// one read port per bank. A query that follows a write reads the new sample.
// Configuration: cfg_we with cfg_wdata writes the efficiency register
// (Q4.12, 4096 is unity); write it only while no query is in flight.
// Reset (rst_n low, synchronous) empties the pipeline and sets efficiency to
// unity; the pattern store is not cleared and must be written before use.
module periodic_bilinear_pattern_lookup_unit
  import pbl_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic                  in_operation,
  input  logic [ANGLE_BITS-1:0] in_azimuth,
  input  logic [ANGLE_BITS-1:0] in_elevation,
  input  logic [ANGLE_BITS-1:0] in_ref_azimuth,
  input  logic [ANGLE_BITS-1:0] in_ref_elevation,
  input  logic [AZ_BITS-1:0]    in_write_az_index,
  input  logic [EL_BITS-1:0]    in_write_el_index,
  input  logic [SAMPLE_W-1:0]   in_write_sample,
  input  logic                  cfg_we,
  input  logic [EFF_W-1:0]      cfg_wdata,
  output logic                  out_strobe,
  output logic [GAIN_W-1:0]     out_gain,
  output logic                  out_saturated
);

  localparam logic [ANGLE_BITS-1:0] HALF_TURN = ANGLE_BITS'(1) << (ANGLE_BITS - 1);

  logic accept;
  logic [ANGLE_BITS-1:0] d_az, d_el;

  logic [EFF_W-1:0] eff_r;

  // stage 1
  logic                  wr_v_r;
  logic [BANK_SEL_W-1:0] wr_bank_r;
  logic [BANK_AW-1:0]    wr_addr_r;
  logic [SAMPLE_W-1:0]   wr_data_r;
  logic                  q_v_r;
  logic [AZ_BITS-1:0]    ai_r;
  logic [EL_BITS-1:0]    ei_r;
  logic [ANGLE_BITS-1:0] t_r, u_r;

  logic [AZ_BITS-1:0] an;
  logic [EL_BITS-1:0] en;
  logic [BANK_AW-1:0] rd_addr [NBANKS];

  // stage 2
  logic                  s2_v_r;
  logic                  par_az_r, par_el_r;
  logic [ANGLE_BITS-1:0] s2_t_r, s2_u_r;
  logic [SAMPLE_W-1:0]   rd_r [NBANKS];

  logic [SAMPLE_W-1:0] mem [NBANKS][BANK_DEPTH];

  pbl_taps_t taps;

  // no clearing pass and no stall source, so the block never holds off
  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign d_az = in_azimuth - in_ref_azimuth + HALF_TURN;
  assign d_el = in_elevation - in_ref_elevation + HALF_TURN;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eff_r <= EFF_RESET;
    end else if (cfg_we) begin
      eff_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_v_r <= 1'b0;
      q_v_r  <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      wr_v_r <= accept && in_operation;
      q_v_r  <= accept && !in_operation;
      s2_v_r <= q_v_r;
    end
  end

  always_ff @(posedge clk) begin
    wr_bank_r <= {in_write_az_index[0], in_write_el_index[0]};
    wr_addr_r <= {in_write_az_index[AZ_BITS-1:1], in_write_el_index[EL_BITS-1:1]};
    wr_data_r <= in_write_sample;
    ai_r      <= d_az[ANGLE_BITS-1 -: AZ_BITS];
    ei_r      <= d_el[ANGLE_BITS-1 -: EL_BITS];
    t_r       <= {d_az[ANGLE_BITS-AZ_BITS-1:0], {AZ_BITS{1'b0}}};
    u_r       <= {d_el[ANGLE_BITS-EL_BITS-1:0], {EL_BITS{1'b0}}};
  end

  // neighbor index wraps at the grid edge
  assign an = ai_r + AZ_BITS'(1);
  assign en = ei_r + EL_BITS'(1);

  // each bank supplies the neighbor whose index parity matches it
  always_comb begin
    logic [AZ_BITS-1:0] az_sel;
    logic [EL_BITS-1:0] el_sel;
    for (int k = 0; k < NBANKS; k++) begin
      az_sel     = (ai_r[0] == 1'((k >> 1) & 1)) ? ai_r : an;
      el_sel     = (ei_r[0] == 1'(k & 1)) ? ei_r : en;
      rd_addr[k] = {az_sel[AZ_BITS-1:1], el_sel[EL_BITS-1:1]};
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NBANKS; k++) begin
      if (wr_v_r && (wr_bank_r == BANK_SEL_W'(k))) begin
        mem[k][wr_addr_r] <= wr_data_r;
      end
      rd_r[k] <= mem[k][rd_addr[k]];
    end
  end

  always_ff @(posedge clk) begin
    par_az_r <= ai_r[0];
    par_el_r <= ei_r[0];
    s2_t_r   <= t_r;
    s2_u_r   <= u_r;
  end

  always_comb begin
    taps.s00 = rd_r[{par_az_r, par_el_r}];
    taps.s10 = rd_r[{~par_az_r, par_el_r}];
    taps.s01 = rd_r[{par_az_r, ~par_el_r}];
    taps.s11 = rd_r[{~par_az_r, ~par_el_r}];
    taps.t   = s2_t_r;
    taps.u   = s2_u_r;
  end

  pbl_blend u_blend (
    .clk           (clk),
    .rst_n         (rst_n),
    .taps_valid    (s2_v_r),
    .taps          (taps),
    .efficiency    (eff_r),
    .out_strobe    (out_strobe),
    .out_gain      (out_gain),
    .out_saturated (out_saturated)
  );

  a_query_enters: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $past(start && !busy && !in_operation) |-> q_v_r)
    else $error("query transfer not captured");

  a_write_enters: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $past(start && !busy && in_operation) |-> wr_v_r && !q_v_r)
    else $error("write transfer not captured");

  a_read_follows: assert property (@(posedge clk) disable iff (!rst_n)
    s2_v_r |-> $past(q_v_r))
    else $error("read stage valid without a query");

endmodule

@@ sv/pbl_blend.sv @@
// bilinear blend, efficiency scale and saturation pipeline
module pbl_blend
  import pbl_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              taps_valid,
  input  pbl_taps_t         taps,
  input  logic [EFF_W-1:0]  efficiency,
  output logic              out_strobe,
  output logic [GAIN_W-1:0] out_gain,
  output logic              out_saturated
);

  localparam int A_W    = SAMPLE_W + ANGLE_BITS;
  localparam int B_W    = SAMPLE_W + 2 * ANGLE_BITS;
  localparam int V_W    = SAMPLE_W + FRAC_OUT;
  localparam int PROD_W = V_W + EFF_W;
  localparam int G_W    = PROD_W + 1 - ROUND_SHIFT;
  localparam int CMP_W  = G_W + GAIN_W;
  localparam logic [ANGLE_BITS:0] FULL       = (ANGLE_BITS + 1)'(1) << ANGLE_BITS;
  localparam logic [PROD_W:0]     ROUND_HALF = (PROD_W + 1)'(1) << (ROUND_SHIFT - 1);
  localparam logic [GAIN_W-1:0]   GAIN_BOUND = GAIN_W'(1) << (PROD_W - ROUND_SHIFT);

  // stage 3: weighted samples along azimuth
  logic                  v3_r;
  logic [A_W-1:0]        p00_r, p10_r, p01_r, p11_r;
  logic [ANGLE_BITS-1:0] u3_r;
  // stage 4: azimuth blends
  logic                  v4_r;
  logic [A_W-1:0]        a0_r, a1_r;
  logic [ANGLE_BITS-1:0] u4_r;
  // stage 5: weighted along elevation
  logic                  v5_r;
  logic [B_W-1:0]        m0_r, m1_r;
  // stage 6: truncated blend
  logic                  v6_r;
  logic [V_W-1:0]        blend_r;
  // stage 7: scaled
  logic                  v7_r;
  logic [PROD_W-1:0]     prod_r;
  // output
  logic                  out_v_r;
  logic [GAIN_W-1:0]     gain_r;
  logic                  sat_r;

  logic [ANGLE_BITS:0] wt, wu;
  logic [B_W-1:0]      b_sum;
  logic [PROD_W:0]     rounded;
  logic [G_W-1:0]      g;
  logic                sat_nxt;
  logic [GAIN_W-1:0]   gain_nxt;

  assign wt = FULL - {1'b0, taps.t};
  assign wu = FULL - {1'b0, u4_r};

  always_comb begin
    b_sum    = m0_r + m1_r;
    rounded  = {1'b0, prod_r} + ROUND_HALF;
    g        = rounded[PROD_W:ROUND_SHIFT];
    sat_nxt  = CMP_W'(g) > CMP_W'(GAIN_MAX);
    gain_nxt = sat_nxt ? GAIN_MAX : GAIN_W'(g);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r    <= 1'b0;
      v4_r    <= 1'b0;
      v5_r    <= 1'b0;
      v6_r    <= 1'b0;
      v7_r    <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      v3_r    <= taps_valid;
      v4_r    <= v3_r;
      v5_r    <= v4_r;
      v6_r    <= v5_r;
      v7_r    <= v6_r;
      out_v_r <= v7_r;
    end
  end

  always_ff @(posedge clk) begin
    p00_r   <= A_W'(taps.s00 * wt);
    p10_r   <= A_W'(taps.s10 * taps.t);
    p01_r   <= A_W'(taps.s01 * wt);
    p11_r   <= A_W'(taps.s11 * taps.t);
    u3_r    <= taps.u;
    a0_r    <= p00_r + p10_r;
    a1_r    <= p01_r + p11_r;
    u4_r    <= u3_r;
    m0_r    <= B_W'(a0_r * wu);
    m1_r    <= B_W'(a1_r * u4_r);
    blend_r <= b_sum[B_W-1:2*ANGLE_BITS-FRAC_OUT];
    prod_r  <= PROD_W'(blend_r * efficiency);
    gain_r  <= gain_nxt;
    sat_r   <= sat_nxt;
  end

  assign out_strobe    = out_v_r;
  assign out_gain      = gain_r;
  assign out_saturated = sat_r & out_v_r;

  // sample and efficiency ranges keep the scaled gain well under the clip level
  a_gain_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> out_gain <= GAIN_BOUND)
    else $error("gain above reachable bound");

  a_no_clip: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !out_saturated)
    else $error("unexpected saturation");

  a_valid_chain: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> $past(v6_r, 2))
    else $error("output valid without matching stage history");

endmodule

@@ tb/tb_periodic_bilinear_pattern_lookup_unit.sv @@
`timescale 1ns / 100ps
// testbench for the periodic bilinear pattern lookup unit
module tb_periodic_bilinear_pattern_lookup_unit;
  import pbl_pkg::*;

  localparam int STORE_DEPTH  = AZ_POINTS * EL_POINTS;
  localparam int HALF_TURN    = 1 << (ANGLE_BITS - 1);
  localparam int DRAIN_CYCLES = 12;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int PHASE_ITEMS  = 210;

  typedef enum logic {
    OP_QUERY = 1'b0,
    OP_WRITE = 1'b1
  } pbl_op_e;

  typedef struct packed {
    logic [GAIN_W-1:0] gain;
    logic              saturated;
  } gain_result_t;

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  logic                  in_operation;
  logic [ANGLE_BITS-1:0] in_azimuth;
  logic [ANGLE_BITS-1:0] in_elevation;
  logic [ANGLE_BITS-1:0] in_ref_azimuth;
  logic [ANGLE_BITS-1:0] in_ref_elevation;
  logic [AZ_BITS-1:0]    in_write_az_index;
  logic [EL_BITS-1:0]    in_write_el_index;
  logic [SAMPLE_W-1:0]   in_write_sample;
  logic                  cfg_we;
  logic [EFF_W-1:0]      cfg_wdata;
  logic                  out_strobe;
  logic [GAIN_W-1:0]     out_gain;
  logic                  out_saturated;

  // predictor state
  logic [SAMPLE_W-1:0] pattern_model [STORE_DEPTH];
  bit                  written_map [STORE_DEPTH];
  logic [EFF_W-1:0]    efficiency_model;
  gain_result_t        gain_expect_q [$];

  int error_count = 0;
  int cycle_count = 0;
  int sent_count  = 0;
  int idle_pct    = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  periodic_bilinear_pattern_lookup_unit u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_operation      (in_operation),
    .in_azimuth        (in_azimuth),
    .in_elevation      (in_elevation),
    .in_ref_azimuth    (in_ref_azimuth),
    .in_ref_elevation  (in_ref_elevation),
    .in_write_az_index (in_write_az_index),
    .in_write_el_index (in_write_el_index),
    .in_write_sample   (in_write_sample),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .out_strobe        (out_strobe),
    .out_gain          (out_gain),
    .out_saturated     (out_saturated)
  );

  // offset from boresight plus half a turn, split into grid index and fraction
  function automatic void split_offset(input logic [ANGLE_BITS-1:0] look,
                                       input logic [ANGLE_BITS-1:0] boresight,
                                       input int points, output int idx,
                                       output longint unsigned frac);
    logic [ANGLE_BITS-1:0] d;
    longint unsigned       p;
    d    = look - boresight + ANGLE_BITS'(HALF_TURN);
    p    = 64'(d) * 64'(points);
    idx  = int'(p >> ANGLE_BITS);
    if (idx >= points) idx = points - 1;
    frac = p & ((64'd1 << ANGLE_BITS) - 1);
  endfunction

  function automatic gain_result_t predict_gain(input logic [ANGLE_BITS-1:0] az,
                                                input logic [ANGLE_BITS-1:0] el,
                                                input logic [ANGLE_BITS-1:0] b_az,
                                                input logic [ANGLE_BITS-1:0] b_el);
    gain_result_t    r;
    int              ai, ei, an, en;
    longint unsigned t, u, full, s00, s10, s01, s11, a0, a1, blend, v, g;
    full = 64'd1 << ANGLE_BITS;
    split_offset(az, b_az, AZ_POINTS, ai, t);
    split_offset(el, b_el, EL_POINTS, ei, u);
    an  = (ai + 1) % AZ_POINTS;
    en  = (ei + 1) % EL_POINTS;
    s00 = pattern_model[ai * EL_POINTS + ei];
    s10 = pattern_model[an * EL_POINTS + ei];
    s01 = pattern_model[ai * EL_POINTS + en];
    s11 = pattern_model[an * EL_POINTS + en];
    a0    = s00 * (full - t) + s10 * t;
    a1    = s01 * (full - t) + s11 * t;
    blend = a0 * (full - u) + a1 * u;
    v     = blend >> (2 * ANGLE_BITS - FRAC_OUT);
    g     = (v * 64'(efficiency_model) + (64'd1 << (ROUND_SHIFT - 1))) >> ROUND_SHIFT;
    r.saturated = 1'b0;
    if (g > 64'(GAIN_MAX)) begin
      g           = 64'(GAIN_MAX);
      r.saturated = 1'b1;
    end
    r.gain = g[GAIN_W-1:0];
    return r;
  endfunction

  function automatic logic [SAMPLE_W-1:0] random_sample();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // random offset, sometimes sitting exactly on a grid point or just below the next
  function automatic logic [ANGLE_BITS-1:0] random_offset();
    logic [ANGLE_BITS-1:0] d;
    d = ANGLE_BITS'($urandom);
    case ($urandom_range(9))
      0:       d[ANGLE_BITS-AZ_BITS-1:0] = '0;
      1:       d[ANGLE_BITS-AZ_BITS-1:0] = '1;
      default: ;
    endcase
    return d;
  endfunction

  // one input transfer, with random sender idle cycles in front
  task automatic send_item(input pbl_op_e op,
                           input logic [ANGLE_BITS-1:0] az, el, b_az, b_el,
                           input logic [AZ_BITS-1:0] w_az, input logic [EL_BITS-1:0] w_el,
                           input logic [SAMPLE_W-1:0] sample);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start             <= 1'b1;
    in_operation      <= op;
    in_azimuth        <= az;
    in_elevation      <= el;
    in_ref_azimuth    <= b_az;
    in_ref_elevation  <= b_el;
    in_write_az_index <= w_az;
    in_write_el_index <= w_el;
    in_write_sample   <= sample;
    do @(posedge clk); while (busy !== 1'b0);
    sent_count++;
    if (op == OP_WRITE) begin
      if (int'(w_az) < AZ_POINTS && int'(w_el) < EL_POINTS) begin
        pattern_model[int'(w_az) * EL_POINTS + int'(w_el)] = sample;
        written_map[int'(w_az) * EL_POINTS + int'(w_el)]   = 1'b1;
      end
    end else begin
      gain_expect_q.push_back(predict_gain(az, el, b_az, b_el));
    end
  endtask

  task automatic write_point(input int az, input int el, input logic [SAMPLE_W-1:0] sample);
    send_item(OP_WRITE, ANGLE_BITS'($urandom), ANGLE_BITS'($urandom), ANGLE_BITS'($urandom),
              ANGLE_BITS'($urandom), AZ_BITS'(az), EL_BITS'(el), sample);
  endtask

  // query by offset; any neighbor not yet written gets a sample first
  task automatic query_offset(input logic [ANGLE_BITS-1:0] d_az, d_el, b_az, b_el);
    logic [ANGLE_BITS-1:0] az, el;
    int                    ai, ei, an, en;
    longint unsigned       t, u;
    az = d_az + b_az - ANGLE_BITS'(HALF_TURN);
    el = d_el + b_el - ANGLE_BITS'(HALF_TURN);
    split_offset(az, b_az, AZ_POINTS, ai, t);
    split_offset(el, b_el, EL_POINTS, ei, u);
    an = (ai + 1) % AZ_POINTS;
    en = (ei + 1) % EL_POINTS;
    if (!written_map[ai * EL_POINTS + ei]) write_point(ai, ei, random_sample());
    if (!written_map[an * EL_POINTS + ei]) write_point(an, ei, random_sample());
    if (!written_map[ai * EL_POINTS + en]) write_point(ai, en, random_sample());
    if (!written_map[an * EL_POINTS + en]) write_point(an, en, random_sample());
    send_item(OP_QUERY, az, el, b_az, b_el, AZ_BITS'($urandom), EL_BITS'($urandom),
              SAMPLE_W'($urandom));
  endtask

  task automatic drain();
    start <= 1'b0;
    while (gain_expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_efficiency(input logic [EFF_W-1:0] value);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we           <= 1'b0;
    efficiency_model = value;
  endtask

  // grid points and the largest fraction, at reset efficiency
  task automatic test_grid_points();
    idle_pct = 0;
    write_point(0, 0, '1);
    write_point(1, 0, '1);
    write_point(0, 1, '1);
    write_point(1, 1, '1);
    query_offset('0, '0, '0, '0);
    query_offset(ANGLE_BITS'(1023), ANGLE_BITS'(1023), '0, '0);
  endtask

  // last grid index wraps to the first; angle extremes
  task automatic test_wrap_edges();
    write_point(AZ_POINTS - 1, EL_POINTS - 1, '0);
    write_point(0, EL_POINTS - 1, '1);
    write_point(AZ_POINTS - 1, 0, '0);
    query_offset('1, '1, '0, '0);
    query_offset(ANGLE_BITS'(HALF_TURN), ANGLE_BITS'(HALF_TURN), '1, '1);
    query_offset(ANGLE_BITS'(HALF_TURN + 1), ANGLE_BITS'(HALF_TURN + 1), '1, '1);
  endtask

  // query in the cycle right after a write to one of its neighbors
  task automatic test_write_then_query();
    write_point(0, 0, '0);
    query_offset('0, '0, '0, '0);
    write_point(1, 1, 16'h8001);
    query_offset(ANGLE_BITS'(512), ANGLE_BITS'(777), '0, '0);
  endtask

  task automatic test_efficiency_extremes();
    set_efficiency('0);
    query_offset(ANGLE_BITS'(1023), ANGLE_BITS'(1023), '0, '0);
    set_efficiency('1);
    query_offset('0, '0, '0, '0);
    query_offset(ANGLE_BITS'(300), ANGLE_BITS'(900), '0, '0);
  endtask

  // mostly queries with random content, a quarter random writes
  task automatic test_random_traffic(input logic [EFF_W-1:0] eff, input int pct,
                                     input int n_items);
    int first;
    set_efficiency(eff);
    idle_pct = pct;
    first    = sent_count;
    while (sent_count - first < n_items) begin
      if ($urandom_range(3) == 0)
        write_point($urandom_range(AZ_POINTS - 1), $urandom_range(EL_POINTS - 1),
                    random_sample());
      else
        query_offset(random_offset(), random_offset(), ANGLE_BITS'($urandom),
                     ANGLE_BITS'($urandom));
    end
  endtask

  // result check, one transfer per strobe cycle
  always @(posedge clk) begin
    gain_result_t want;
    if (rst_n === 1'b1 && out_strobe !== 1'b0) begin
      if (gain_expect_q.size() == 0) begin
        $error("out_strobe with no query outstanding");
        error_count++;
      end else begin
        want = gain_expect_q.pop_front();
        if (out_gain !== want.gain) begin
          $error("out_gain expected %0d got %0d", want.gain, out_gain);
          error_count++;
        end
        if (out_saturated !== want.saturated) begin
          $error("out_saturated expected %0d got %0d", want.saturated, out_saturated);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("periodic_bilinear_pattern_lookup_unit verification failed");
      $finish;
    end
  end

  initial begin
    rst_n             <= 1'b0;
    start             <= 1'b0;
    in_operation      <= OP_QUERY;
    in_azimuth        <= '0;
    in_elevation      <= '0;
    in_ref_azimuth    <= '0;
    in_ref_elevation  <= '0;
    in_write_az_index <= '0;
    in_write_el_index <= '0;
    in_write_sample   <= '0;
    cfg_we            <= 1'b0;
    cfg_wdata         <= '0;
    efficiency_model  = EFF_RESET;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    test_grid_points();
    test_wrap_edges();
    test_write_then_query();
    test_efficiency_extremes();
    test_random_traffic(EFF_RESET, 0, PHASE_ITEMS);
    test_random_traffic('1, 52, PHASE_ITEMS);
    test_random_traffic(EFF_W'($urandom), 28, PHASE_ITEMS);
    test_random_traffic(EFF_W'($urandom_range(1, 8191)), 0, PHASE_ITEMS);

    drain();
    if (error_count == 0)
      $display("periodic_bilinear_pattern_lookup_unit verification clean");
    else
      $display("periodic_bilinear_pattern_lookup_unit verification failed");
    $finish;
  end

endmodule

@@ periodic_bilinear_pattern_lookup_unit.f @@
sv/pbl_pkg.sv
sv/pbl_blend.sv
sv/periodic_bilinear_pattern_lookup_unit.sv
tb/tb_periodic_bilinear_pattern_lookup_unit.sv
